@@ rtl/csvd_pkg.sv @@
// csvd_pkg: shared types, constants and the exp table function for the softmax vote debouncer
// depends on nothing; imported by every module of the block
package csvd_pkg;

    localparam int LOGIT_FIELDS = 8;
    localparam int LOGIT_W      = 16;
    localparam int PROB_W       = 16;
    localparam int EXP_W        = 17;
    localparam int SUM_W        = 20;
    localparam int CLS_W        = 3;
    localparam int CNT_W        = 8;
    localparam int REG_CONF_THR = 0;
    localparam int REG_NBIAS    = 1;
    localparam int REG_CONFIRM  = 2;
    localparam int REG_IGN_NEUT = 3;
    localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748381;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MAX   = 7'b0000010,
        ST_EXP   = 7'b0000100,
        ST_DIV   = 7'b0001000,
        ST_ARG   = 7'b0010000,
        ST_VOTE  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       max_step;
        logic       exp_step;
        logic       div_start;
        logic       div_step;
        logic       arg_step;
        logic       vote;
        logic [2:0] idx;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic bypass;
    } status_t;

    // exp entry k, round-half-up of T[k] / 2^14; iterates at elaboration only
    function automatic logic [EXP_W-1:0] exp_entry(input int k);
        logic [63:0] t;
        logic [63:0] prod;
        t = 64'd1 << 30;
        for (int j = 0; j < k; j++)
        begin
            prod = t * EXP_STEP_Q32 + (64'd1 << 31);
            t    = prod >> 32;
        end
        exp_entry = EXP_W'((t + (64'd1 << 13)) >> 14);
    endfunction

endpackage

@@ rtl/csvd_ctrl.sv @@
// csvd_ctrl: sequencing state machine of the softmax vote debouncer
// depends on csvd_pkg
module csvd_ctrl
    import csvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    out_taken,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    out_valid
);

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        cmd           = '0;
        cmd.idx       = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_MAX;
                end
            end
            ST_MAX:
            begin
                if (status.bypass)
                    state_next = ST_VOTE;
                else
                begin
                    cmd.max_step = 1'b1;
                    idx_next     = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                        state_next = ST_EXP;
                end
            end
            ST_EXP:
            begin
                cmd.exp_step = 1'b1;
                idx_next     = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                        state_next = ST_ARG;
                    else
                        cmd.div_start = 1'b1;
                end
            end
            ST_ARG:
            begin
                cmd.arg_step = 1'b1;
                idx_next     = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                    state_next = ST_VOTE;
            end
            ST_VOTE:
            begin
                cmd.vote   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_taken)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy      = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

@@ rtl/csvd_datapath.sv @@
// csvd_datapath: logit store, max search, exp lookup, serial divider, argmax and vote state
// depends on csvd_pkg
module csvd_datapath
    import csvd_pkg::*;
#(
    parameter int NUM_CLASSES     = 8,
    parameter int NEUTRAL_INDEX   = 0,
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   status,
    input  logic                      in_op,
    input  logic                      in_face,
    input  logic                      in_ok,
    input  logic [8*LOGIT_W-1:0]      in_logits,
    input  logic [PROB_W-1:0]         conf_thr,
    input  logic [PROB_W-1:0]         nbias,
    input  logic [CNT_W-1:0]          confirm_frames,
    input  logic                      ignore_neutral,
    output logic                      res_face,
    output logic [CLS_W-1:0]          res_cls,
    output logic [PROB_W-1:0]         res_conf,
    output logic                      res_changed
);

    localparam int NCLS = (NUM_CLASSES > LOGIT_FIELDS) ? LOGIT_FIELDS : NUM_CLASSES;
    localparam int KW   = LOGIT_W + 1 - 4;

    logic [EXP_W-1:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar g = 0; g < EXP_TABLE_DEPTH; g++)
    begin : g_rom
        assign exp_rom[g] = exp_entry(g);
    end

    logic signed [LOGIT_W-1:0] lg_reg [LOGIT_FIELDS];
    logic [EXP_W-1:0]  ex_reg [LOGIT_FIELDS];
    logic [PROB_W-1:0] pr_reg [LOGIT_FIELDS];
    logic signed [LOGIT_W-1:0] max_reg;
    logic [SUM_W-1:0] sum_reg;
    logic op_reg, face_reg, ok_reg;
    logic [CLS_W-1:0]  best_reg;
    logic [PROB_W:0]   best_sel_reg;
    // restoring divider
    logic [EXP_W+PROB_W-1:0] quo_reg;
    logic [SUM_W:0]          rem_reg;
    logic [5:0]              dcnt_reg;

    logic [CLS_W-1:0] vote_class_reg, conf_class_reg;
    logic             vote_valid_reg, conf_valid_reg;
    logic [CNT_W-1:0] vote_count_reg;
    logic             changed_reg;

    logic idx_used;
    assign idx_used = (int'(cmd.idx) < NCLS);

    // exp index of current class
    logic signed [LOGIT_W:0] diff;
    logic [KW-1:0]           kidx;
    logic [EXP_W-1:0]        ex_cur;
    assign diff   = (LOGIT_W+1)'(max_reg) - (LOGIT_W+1)'(lg_reg[cmd.idx]);
    assign kidx   = KW'(diff >>> 4);
    assign ex_cur = (kidx < KW'(EXP_TABLE_DEPTH)) ?
                    exp_rom[kidx[$clog2(EXP_TABLE_DEPTH)-1:0]] : '0;

    // divider step
    logic [SUM_W:0]  rem_sh;
    logic [SUM_W:0]  rem_sub;
    assign rem_sh  = {rem_reg[SUM_W-1:0], quo_reg[EXP_W+PROB_W-1]};
    assign rem_sub = rem_sh - {1'b0, sum_reg};

    // argmax score
    logic [PROB_W:0]  sel_cur;
    logic [2*PROB_W:0] nprod;
    assign nprod   = (2*PROB_W+1)'(pr_reg[cmd.idx]) * ((2*PROB_W+1)'(17'd65536) -
                     (2*PROB_W+1)'(nbias));
    assign sel_cur = (int'(cmd.idx) == NEUTRAL_INDEX) ? (PROB_W+1)'(nprod >> 16)
                                                      : (PROB_W+1)'(pr_reg[cmd.idx]);

    assign status.div_done = (dcnt_reg == 6'd1);
    assign status.bypass   = op_reg || !face_reg || !ok_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_op;
            face_reg <= in_face;
            ok_reg   <= in_ok;
            for (int i = 0; i < LOGIT_FIELDS; i++)
                lg_reg[i] <= in_logits[i*LOGIT_W +: LOGIT_W];
            max_reg  <= in_logits[LOGIT_W-1:0];
            sum_reg  <= '0;
            best_reg <= '0;
            best_sel_reg <= '0;
        end
        if (cmd.max_step && idx_used && (lg_reg[cmd.idx] > max_reg))
            max_reg <= lg_reg[cmd.idx];
        if (cmd.exp_step)
        begin
            ex_reg[cmd.idx] <= idx_used ? ex_cur : '0;
            sum_reg <= sum_reg + (idx_used ? SUM_W'(ex_cur) : '0);
        end
        if (cmd.div_step && dcnt_reg != 6'd0)
        begin
            if (!rem_sub[SUM_W])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[EXP_W+PROB_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[EXP_W+PROB_W-2:0], 1'b0};
            end
            if (dcnt_reg == 6'd1)
                pr_reg[cmd.idx] <= (rem_sub[SUM_W] ?
                    ({quo_reg[EXP_W+PROB_W-2:0], 1'b0} > 33'd65535) :
                    ({quo_reg[EXP_W+PROB_W-2:0], 1'b1} > 33'd65535)) ? 16'hFFFF :
                    (rem_sub[SUM_W] ? {quo_reg[PROB_W-2:0], 1'b0}
                                    : {quo_reg[PROB_W-2:0], 1'b1});
        end
        if (cmd.div_start)
        begin
            quo_reg <= {ex_reg[cmd.div_step ? cmd.idx + 3'd1 : 3'd0], {PROB_W{1'b0}}};
            rem_reg <= '0;
        end
        if (cmd.arg_step && idx_used && (cmd.idx == 3'd0 || sel_cur > best_sel_reg))
        begin
            best_sel_reg <= sel_cur;
            best_reg     <= cmd.idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= 6'(EXP_W + PROB_W);
        else if (cmd.div_step && dcnt_reg != 6'd0)
            dcnt_reg <= dcnt_reg - 6'd1;
    end

    // vote and result state
    logic [PROB_W-1:0] win_p;
    assign win_p = pr_reg[best_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vote_class_reg <= '0;
            vote_valid_reg <= 1'b0;
            vote_count_reg <= '0;
            conf_class_reg <= CLS_W'(NEUTRAL_INDEX);
            conf_valid_reg <= 1'b0;
            changed_reg    <= 1'b0;
            res_face       <= 1'b0;
            res_cls        <= '0;
            res_conf       <= '0;
        end
        else if (cmd.vote)
        begin
            logic [CNT_W-1:0] cnt_n;
            logic [CLS_W-1:0] cls_n;
            cnt_n = vote_count_reg;
            cls_n = vote_class_reg;
            res_face    <= 1'b0;
            res_cls     <= '0;
            res_conf    <= '0;
            changed_reg <= 1'b0;
            priority if (op_reg)
            begin
                conf_valid_reg <= 1'b0;
                conf_class_reg <= CLS_W'(NEUTRAL_INDEX);
                vote_valid_reg <= 1'b0;
                vote_count_reg <= '0;
            end
            else if (!face_reg)
                vote_valid_reg <= 1'b0;
            else if (!ok_reg)
                res_face <= 1'b1;
            else
            begin
                res_face <= 1'b1;
                res_cls  <= best_reg;
                res_conf <= win_p;
                if (win_p >= conf_thr)
                begin
                    if (!vote_valid_reg || best_reg != vote_class_reg)
                    begin
                        cls_n = best_reg;
                        cnt_n = 8'd1;
                    end
                    else if (vote_count_reg != 8'd255)
                        cnt_n = vote_count_reg + 8'd1;
                    vote_class_reg <= cls_n;
                    vote_count_reg <= cnt_n;
                    vote_valid_reg <= 1'b1;
                    if (cnt_n >= confirm_frames)
                    begin
                        changed_reg <= (!conf_valid_reg || cls_n != conf_class_reg) &&
                            !(ignore_neutral && int'(cls_n) == NEUTRAL_INDEX);
                        conf_class_reg <= cls_n;
                        conf_valid_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign res_changed = changed_reg;

endmodule

@@ rtl/class_softmax_vote_debouncer_unit.sv @@
// class_softmax_vote_debouncer_unit: top level with stream ports and apb register port
// depends on csvd_pkg, csvd_ctrl and csvd_datapath

// One frame transfer goes in at a time. A clear, a no-face or an inference-fail frame
// skips from the max-search state straight to the vote step; an evaluated frame runs
// eight max-search steps, eight exp lookups, then eight quotients from a bit-serial
// restoring divider, eight argmax steps and one vote step. The result sits in a register
// until taken, and the next frame is taken once it has gone. The user must write the
// registers only while no frame is in work; the block itself does not enforce this.
module class_softmax_vote_debouncer_unit
    import csvd_pkg::*;
#(
    parameter int NUM_CLASSES     = 8,
    parameter int NEUTRAL_INDEX   = 0,
    parameter int EXP_TABLE_DEPTH = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    // op, face_present, inference_ok
    input  logic [2:0]   s_tuser,
    // logit_0 .. logit_7, 16 bits each from the lowest bit up
    input  logic [127:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // face_seen, dominant_class[3], confidence[16], changed, trigger; padded to 24 bits
    output logic [23:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0] thr_reg, nbias_reg;
    logic [7:0]  confirm_reg;
    logic        ign_reg;
    cmd_t        cmd;
    status_t     status;
    logic        busy;
    logic        res_face, res_changed;
    logic [2:0]  res_cls;
    logic [15:0] res_conf;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= 16'd32768;
            nbias_reg   <= 16'd0;
            confirm_reg <= 8'd3;
            ign_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                2'(REG_CONF_THR): thr_reg     <= pwdata[15:0];
                2'(REG_NBIAS):    nbias_reg   <= pwdata[15:0];
                2'(REG_CONFIRM):  confirm_reg <= pwdata[7:0];
                default:          ign_reg     <= pwdata[0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            2'(REG_CONF_THR): prdata = {16'd0, thr_reg};
            2'(REG_NBIAS):    prdata = {16'd0, nbias_reg};
            2'(REG_CONFIRM):  prdata = {24'd0, confirm_reg};
            default:          prdata = {31'd0, ign_reg};
        endcase
    end

    assign s_tready = !busy;

    csvd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && s_tready),
        .out_taken (m_tready),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .out_valid (m_tvalid)
    );

    csvd_datapath #(
        .NUM_CLASSES     (NUM_CLASSES),
        .NEUTRAL_INDEX   (NEUTRAL_INDEX),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_op          (s_tuser[0]),
        .in_face        (s_tuser[1]),
        .in_ok          (s_tuser[2]),
        .in_logits      (s_tdata),
        .conf_thr       (thr_reg),
        .nbias          (nbias_reg),
        .confirm_frames (confirm_reg),
        .ignore_neutral (ign_reg),
        .res_face       (res_face),
        .res_cls        (res_cls),
        .res_conf       (res_conf),
        .res_changed    (res_changed)
    );

    // trigger: face seen, changed, confidence at threshold (changed already implies both)
    assign m_tdata = {2'b00, res_changed && res_face && (res_conf >= thr_reg),
                      res_changed, res_conf, res_cls, res_face};

    // a result is only offered while no new frame is taken
    assert property (@(posedge clk) disable iff (!rst_n) m_tvalid |-> !s_tready)
        else $error("result offered while input ready");
    // a result without a face (clear or no-face frame) is all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[20:1] == 20'd0))
        else $error("no-face result not zero");
    // the trigger never stands without the change flag
    assert property (@(posedge clk) disable iff (!rst_n) m_tdata[21] |-> m_tdata[20])
        else $error("trigger without change");

endmodule
